/* rtl/lstp_pkg.sv */
// Shared types and constants for the linear sieve / truncatable prime block.
// No dependencies; imported by lstp_sieve and linear_sieve_truncatable_prime.
`timescale 1ns / 1ps

package lstp_pkg;

    // Field widths fixed by the interface
    localparam int VAL_W  = 16;
    localparam int STAT_W = 2;

    // Storage sizes
    localparam int MAX_VALUE   = 65536;
    localparam int PRIME_SLOTS = 8192;
    localparam int MAP_AW      = $clog2(MAX_VALUE);
    localparam int PL_AW       = $clog2(PRIME_SLOTS);
    localparam int CNT_W       = PL_AW + 1;
    localparam int PROD_W      = 2 * VAL_W;

    localparam logic [VAL_W-1:0] LIMIT_RESET = 16'd65535;
    localparam logic [VAL_W-1:0] LIMIT_CAP   = VAL_W'(MAX_VALUE - 1);
    localparam logic [VAL_W-1:0] FIRST_PRIME = 16'd2;

    // x / 10 == (x * 52429) >> 19 for every 16-bit x
    localparam logic [VAL_W-1:0] DIV10_MUL   = 16'd52429;
    localparam int               DIV10_SHIFT = 19;

    // Command codes (tuser on the input side)
    localparam logic CMD_BUILD = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // Status codes (tuser on the output side)
    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_NOT_BUILT = 2'd1;
    localparam logic [STAT_W-1:0] ST_RANGE     = 2'd2;
    localparam logic [STAT_W-1:0] ST_BUILT     = 2'd3;

    // Composite map entry: flag plus prime-list index of the smallest factor
    typedef struct packed {
        logic             comp;
        logic [PL_AW-1:0] spf_idx;
    } map_entry_t;

    typedef struct packed {
        logic             valid;
        logic             build;
        logic [VAL_W-1:0] value;
        logic [VAL_W-1:0] limit;
    } req_t;

    typedef struct packed {
        logic              valid;
        logic [STAT_W-1:0] status;
        logic              is_prime;
        logic              all_prefixes_prime;
    } rsp_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLEAR,
        S_RD_I,
        S_CHK_I,
        S_P_RD,
        S_P_MUL,
        S_P_CHK,
        S_NEXT_I,
        S_Q_RD,
        S_Q_CHK,
        S_DONE
    } state_t;

endpackage

/* rtl/lstp_sieve.sv */
// Sieve engine: composite map and prime list memories plus the build/query sequencer.
// Depends on lstp_pkg.
`timescale 1ns / 1ps

module lstp_sieve (
    input  logic          clk,
    input  logic          rst_n,
    input  lstp_pkg::req_t req,
    output logic          idle,
    output lstp_pkg::rsp_t rsp,
    input  logic          rsp_ready
);
    import lstp_pkg::*;

    // Memories
    map_entry_t       cmap_mem [MAX_VALUE];
    logic [VAL_W-1:0] pl_mem   [PRIME_SLOTS];
    map_entry_t       cmap_rd_reg;
    logic [VAL_W-1:0] pl_rd_reg;

    logic              cmap_we, cmap_re;
    logic [MAP_AW-1:0] cmap_waddr, cmap_raddr;
    map_entry_t        cmap_wdata;
    logic              pl_we, pl_re;
    logic [PL_AW-1:0]  pl_waddr, pl_raddr;
    logic [VAL_W-1:0]  pl_wdata;

    state_t state_reg, state_next;

    logic [VAL_W-1:0]  lim_reg, lim_next;
    logic [VAL_W-1:0]  built_lim_reg, built_lim_next;
    logic              ready_reg, ready_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [VAL_W-1:0]  i_reg, i_next;
    logic [PL_AW-1:0]  j_reg, j_next;
    logic [PL_AW-1:0]  cur_idx_reg, cur_idx_next;
    logic              known_reg, known_next;
    logic [PROD_W-1:0] prod_reg, prod_next;
    logic [VAL_W-1:0]  num_reg, num_next;
    logic              first_reg, first_next;
    logic [STAT_W-1:0] status_reg, status_next;
    logic              isp_reg, isp_next;
    logic              allp_reg, allp_next;

    logic [VAL_W-1:0]  eff_lim;
    logic [PROD_W-1:0] q10_prod;
    logic [VAL_W-1:0]  num_div10;
    logic              num_prime;
    logic              last_j;
    logic              spf_hit;

    assign eff_lim   = (req.limit > LIMIT_CAP) ? LIMIT_CAP : req.limit;
    assign q10_prod  = num_reg * DIV10_MUL;
    assign num_div10 = VAL_W'(q10_prod >> DIV10_SHIFT);
    assign num_prime = (num_reg >= FIRST_PRIME) && !cmap_rd_reg.comp;
    assign last_j    = ((CNT_W'(j_reg) + CNT_W'(1)) == cnt_reg);
    assign spf_hit   = known_reg && (j_reg == cur_idx_reg);

    always_ff @(posedge clk)
    begin
        if (cmap_we)
        begin
            cmap_mem[cmap_waddr] <= cmap_wdata;
        end
        if (cmap_re)
        begin
            cmap_rd_reg <= cmap_mem[cmap_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (pl_we)
        begin
            pl_mem[pl_waddr] <= pl_wdata;
        end
        if (pl_re)
        begin
            pl_rd_reg <= pl_mem[pl_raddr];
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    if (req.build)
                    begin
                        state_next = S_CLEAR;
                    end
                    else if (!ready_reg || (req.value > built_lim_reg))
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_Q_RD;
                    end
                end
            end
            S_CLEAR:
            begin
                if (i_reg == lim_reg)
                begin
                    state_next = (lim_reg < FIRST_PRIME) ? S_DONE : S_RD_I;
                end
            end
            S_RD_I:
            begin
                state_next = S_CHK_I;
            end
            S_CHK_I:
            begin
                state_next = (cnt_next == '0) ? S_NEXT_I : S_P_RD;
            end
            S_P_RD:
            begin
                state_next = S_P_MUL;
            end
            S_P_MUL:
            begin
                state_next = S_P_CHK;
            end
            S_P_CHK:
            begin
                if ((prod_reg > PROD_W'(lim_reg)) || spf_hit || last_j)
                begin
                    state_next = S_NEXT_I;
                end
                else
                begin
                    state_next = S_P_RD;
                end
            end
            S_NEXT_I:
            begin
                state_next = (i_reg == lim_reg) ? S_DONE : S_RD_I;
            end
            S_Q_RD:
            begin
                state_next = S_Q_CHK;
            end
            S_Q_CHK:
            begin
                if (!num_prime || (num_div10 == '0))
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_Q_RD;
                end
            end
            S_DONE:
            begin
                if (rsp_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Outputs and datapath
    always_comb
    begin
        cmap_we        = 1'b0;
        cmap_waddr     = MAP_AW'(prod_reg);
        cmap_wdata     = '{comp: 1'b1, spf_idx: j_reg};
        cmap_re        = 1'b0;
        cmap_raddr     = MAP_AW'(i_reg);
        pl_we          = 1'b0;
        pl_waddr       = PL_AW'(cnt_reg);
        pl_wdata       = i_reg;
        pl_re          = 1'b0;
        pl_raddr       = j_reg;
        lim_next       = lim_reg;
        built_lim_next = built_lim_reg;
        ready_next     = ready_reg;
        cnt_next       = cnt_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        cur_idx_next   = cur_idx_reg;
        known_next     = known_reg;
        prod_next      = prod_reg;
        num_next       = num_reg;
        first_next     = first_reg;
        status_next    = status_reg;
        isp_next       = isp_reg;
        allp_next      = allp_reg;
        idle           = 1'b0;
        rsp            = '{valid: 1'b0, status: status_reg, is_prime: isp_reg,
                           all_prefixes_prime: allp_reg};
        case (state_reg)
            S_IDLE:
            begin
                idle      = 1'b1;
                isp_next  = 1'b0;
                allp_next = 1'b0;
                if (req.valid)
                begin
                    if (req.build)
                    begin
                        lim_next = eff_lim;
                        cnt_next = '0;
                        i_next   = '0;
                    end
                    else if (!ready_reg)
                    begin
                        status_next = ST_NOT_BUILT;
                    end
                    else if (req.value > built_lim_reg)
                    begin
                        status_next = ST_RANGE;
                    end
                    else
                    begin
                        status_next = ST_OK;
                        num_next    = req.value;
                        first_next  = 1'b1;
                    end
                end
            end
            S_CLEAR:
            begin
                cmap_we    = 1'b1;
                cmap_waddr = MAP_AW'(i_reg);
                cmap_wdata = '0;
                if (i_reg == lim_reg)
                begin
                    i_next = FIRST_PRIME;
                    if (lim_reg < FIRST_PRIME)
                    begin
                        built_lim_next = lim_reg;
                        ready_next     = 1'b1;
                        status_next    = ST_BUILT;
                    end
                end
                else
                begin
                    i_next = i_reg + VAL_W'(1);
                end
            end
            S_RD_I:
            begin
                cmap_re = 1'b1;
            end
            S_CHK_I:
            begin
                j_next = '0;
                if (cmap_rd_reg.comp)
                begin
                    cur_idx_next = cmap_rd_reg.spf_idx;
                    known_next   = 1'b1;
                end
                else if (cnt_reg < CNT_W'(PRIME_SLOTS))
                begin
                    // new prime: append and remember its slot as its own factor
                    pl_we        = 1'b1;
                    cur_idx_next = PL_AW'(cnt_reg);
                    known_next   = 1'b1;
                    cnt_next     = cnt_reg + CNT_W'(1);
                end
                else
                begin
                    known_next = 1'b0;
                end
            end
            S_P_RD:
            begin
                pl_re = 1'b1;
            end
            S_P_MUL:
            begin
                prod_next = pl_rd_reg * i_reg;
            end
            S_P_CHK:
            begin
                if (prod_reg <= PROD_W'(lim_reg))
                begin
                    cmap_we = 1'b1;
                    j_next  = j_reg + PL_AW'(1);
                end
            end
            S_NEXT_I:
            begin
                if (i_reg == lim_reg)
                begin
                    built_lim_next = lim_reg;
                    ready_next     = 1'b1;
                    status_next    = ST_BUILT;
                end
                else
                begin
                    i_next = i_reg + VAL_W'(1);
                end
            end
            S_Q_RD:
            begin
                cmap_re    = 1'b1;
                cmap_raddr = MAP_AW'(num_reg);
            end
            S_Q_CHK:
            begin
                first_next = 1'b0;
                if (first_reg)
                begin
                    isp_next = num_prime;
                end
                if (!num_prime)
                begin
                    allp_next = 1'b0;
                end
                else if (num_div10 == '0)
                begin
                    allp_next = 1'b1;
                end
                else
                begin
                    num_next = num_div10;
                end
            end
            S_DONE:
            begin
                rsp.valid = 1'b1;
            end
            default:
            begin
                idle = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            built_lim_reg <= '0;
            ready_reg     <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            built_lim_reg <= built_lim_next;
            ready_reg     <= ready_next;
            cnt_reg       <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lim_reg     <= lim_next;
        i_reg       <= i_next;
        j_reg       <= j_next;
        cur_idx_reg <= cur_idx_next;
        known_reg   <= known_next;
        prod_reg    <= prod_next;
        num_reg     <= num_next;
        first_reg   <= first_next;
        status_reg  <= status_next;
        isp_reg     <= isp_next;
        allp_reg    <= allp_next;
    end

endmodule

/* rtl/linear_sieve_truncatable_prime.sv */
// Top level: stream ports, limit register and output word register around lstp_sieve.
// Depends on lstp_pkg and lstp_sieve.
`timescale 1ns / 1ps

// Build and query engine for a 64K-entry linear (Euler) sieve. A build word
// (tuser = 0) first sweeps the composite map from 0 to the limit, one entry a
// cycle, then visits every value from 2 to the limit in the steps read,
// check and next, and for each prime probed against it in the steps read,
// multiply and check; each composite is probed once. A query word reads and
// checks the map once for each decimal prefix. These steps come from the one
// read port and one write port of the composite map and the one-probe-at-a-time
// walk over the prime list. One word is worked on at a time; the next input
// word is taken as soon as the result is parked in the output register. The
// sieve limit is written through cfg_wr_en and takes effect at the next build.
module linear_sieve_truncatable_prime (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [lstp_pkg::VAL_W-1:0]  cfg_wr_data,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [lstp_pkg::VAL_W-1:0]  s_tdata,   // [15:0] value
    input  logic                        s_tuser,   // [0] cmd
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [7:0]                  m_tdata,   // [0] is_prime, [1] all_prefixes_prime
    output logic [lstp_pkg::STAT_W-1:0] m_tuser    // [1:0] status
);
    import lstp_pkg::*;

    logic [VAL_W-1:0]  limit_reg;
    logic              out_valid_reg, out_valid_next;
    logic [STAT_W-1:0] out_status_reg;
    logic              out_isp_reg;
    logic              out_allp_reg;
    logic              core_idle;
    logic              rsp_ready;
    logic              load_out;
    req_t              req;
    rsp_t              rsp;

    assign s_tready  = core_idle;
    assign req.valid = s_tvalid && core_idle;
    assign req.build = (s_tuser == CMD_BUILD);
    assign req.value = s_tdata;
    assign req.limit = limit_reg;

    // Output register frees the engine as soon as a word is parked
    assign rsp_ready = !out_valid_reg || m_tready;
    assign load_out  = rsp.valid && rsp_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    lstp_sieve u_sieve (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .idle      (core_idle),
        .rsp       (rsp),
        .rsp_ready (rsp_ready)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg     <= LIMIT_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                limit_reg <= cfg_wr_data;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_status_reg <= rsp.status;
            out_isp_reg    <= rsp.is_prime;
            out_allp_reg   <= rsp.all_prefixes_prime;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {6'b000000, out_allp_reg, out_isp_reg};

`ifndef ASSERT_OFF
    // One word at a time: an accepted word always makes the engine busy
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted twice in a row");

    // A build result carries no prime flags
    a_build_flags_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser == ST_BUILT)) |-> (m_tdata[1:0] == 2'b00))
        else $error("build result with prime flags set");

    // Right-truncatable implies prime
    a_prefix_implies_prime: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[1]) |-> m_tdata[0])
        else $error("all_prefixes_prime without is_prime");
`endif

endmodule
